// File: rtl/assert_macros.svh
// assertion macros shared by the monitor rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold at a clock edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// when pre holds, post must hold at the same edge
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: rtl/fitm_pkg.sv
// shared constants, widths, codes and control structs for the flux interval monitor
// no dependencies
`timescale 1ns / 1ps

package fitm_pkg;

    // histogram and log geometry
    localparam int HIST_BUCKETS = 1024;
    localparam int BUCKET_NS    = 10;
    localparam int LOG_DEPTH    = 4096;

    // field widths
    localparam int LAT_W    = 16;
    localparam int POS_W    = 32;
    localparam int CNT_W    = 32;
    localparam int DEV_W    = 8;
    localparam int THR_W    = 8;
    localparam int TIMING_W = 40;
    localparam int FILL_W   = 13;

    localparam int HIST_AW      = $clog2(HIST_BUCKETS);
    localparam int LOG_AW       = $clog2(LOG_DEPTH);
    localparam int LOG_CW       = $clog2(LOG_DEPTH + 1);
    localparam int HIST_SPAN_NS = HIST_BUCKETS * BUCKET_NS;

    // bucket index by reciprocal multiply, exact for any 16-bit latency
    localparam int RECIP_SH = 22;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int RECIP    = (2 ** RECIP_SH + BUCKET_NS - 1) / BUCKET_NS;
    localparam int PROD_W   = LAT_W + RECIP_W;

    // deviation percent
    localparam int PCT_SCALE   = 100;
    localparam int DVD_W       = 23;
    localparam int DIV_CW      = $clog2(DVD_W);
    localparam int DEV_MAX     = 127;
    localparam int DEV_MIN_MAG = 128;
    localparam int THR_RESET   = 10;

    // command codes
    typedef enum logic [1:0] {
        CMD_RECORD  = 2'd0,
        CMD_HIST_RD = 2'd1,
        CMD_LOG_RD  = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // interval classification
    typedef enum logic [1:0] {
        BT_NORMAL = 2'd0,
        BT_LONG   = 2'd1,
        BT_SHORT  = 2'd2
    } bit_type_t;

    typedef struct packed {
        logic rd_en;
        logic inc_en;
    } hist_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic append_en;
    } log_ctl_t;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [TIMING_W-1:0] timing;
    } log_entry_t;

endpackage

// File: rtl/fitm_div.sv
// restoring divider, one quotient bit per cycle, for the deviation percent
// depends on fitm_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fitm_div
    import fitm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [LAT_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0]  dq_reg;
    logic [LAT_W-1:0]  rem_reg;
    logic [LAT_W-1:0]  dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [LAT_W:0] rem_sh;
    logic [LAT_W:0] rem_sub;
    logic           ge;
    logic [LAT_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? rem_sub[LAT_W-1:0] : rem_sh[LAT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CW'(DVD_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

    `ASSERT_NEVER(a_div_restart, start && busy_reg, "divider started while busy")

endmodule

// File: rtl/fitm_hist.sv
// histogram bucket memory with post-reset clearing sweep, read and increment
// depends on fitm_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fitm_hist
    import fitm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  hist_ctl_t          ctl,
    input  logic [HIST_AW-1:0] rd_addr,
    output logic [CNT_W-1:0]   rd_data,
    output logic               clr_busy
);

    logic [CNT_W-1:0]   mem [HIST_BUCKETS];
    logic [CNT_W-1:0]   rd_data_reg;
    logic [HIST_AW-1:0] addr_reg;
    logic [HIST_AW-1:0] clr_addr_reg;
    logic               clr_busy_reg;

    // clearing sweep, one bucket per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == HIST_AW'(HIST_BUCKETS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + HIST_AW'(1);
        end
    end

    // read, then write back the incremented count at the address last read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (ctl.inc_en)
        begin
            mem[addr_reg] <= rd_data_reg + CNT_W'(1);
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

    `ASSERT_NEVER(a_inc_in_clear, ctl.inc_en && clr_busy_reg, "increment during clear sweep")
    `ASSERT_NEVER(a_rd_in_clear, ctl.rd_en && clr_busy_reg, "read during clear sweep")

endmodule

// File: rtl/fitm_log.sv
// anomaly log memory with fill count, append and indexed read
// depends on fitm_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fitm_log
    import fitm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  log_ctl_t          ctl,
    input  logic [POS_W-1:0]  rd_idx,
    input  log_entry_t        wr_entry,
    output log_entry_t        rd_entry,
    output logic              rd_hit,
    output logic [LOG_CW-1:0] count,
    output logic              full
);

    log_entry_t        mem [LOG_DEPTH];
    log_entry_t        rd_entry_reg;
    logic              rd_hit_reg;
    logic [LOG_CW-1:0] count_reg;

    assign full = (count_reg == LOG_CW'(LOG_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.append_en && !full)
            begin
                count_reg <= count_reg + LOG_CW'(1);
            end
            if (ctl.rd_en)
            begin
                rd_hit_reg <= (rd_idx < POS_W'(count_reg));
            end
        end
    end

    // entries past the fill count are still read out, but with rd_hit low
    always_ff @(posedge clk)
    begin
        if (ctl.append_en && !full)
        begin
            mem[count_reg[LOG_AW-1:0]] <= wr_entry;
        end
        if (ctl.rd_en)
        begin
            rd_entry_reg <= mem[rd_idx[LOG_AW-1:0]];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_hit   = rd_hit_reg;
    assign count    = count_reg;

    `ASSERT_NEVER(a_append_full, ctl.append_en && full, "append to a full log")

endmodule

// File: rtl/flux_interval_timing_monitor_unit.sv
// record: accept, lookup, divide when the expected value is nonzero (in the
// one-bit-per-cycle divider), evaluate, then update; reads skip the divide
// one item at a time: next beat taken the cycle after its result is registered
// reset: histogram clear sweep (one bucket per cycle), in_stall high
// meanwhile; threshold resets to 10 and cfg writes are taken during the sweep
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flux_interval_timing_monitor_unit
    import fitm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // threshold register
    input  logic                    cfg_wr_en,
    input  logic [THR_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [POS_W-1:0]        bit_pos,
    input  logic [LAT_W-1:0]        interval_ns,
    input  logic [LAT_W-1:0]        nominal_ns,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [DEV_W-1:0] dev_pct,
    output logic [1:0]              bit_type,
    output logic                    logged,
    output logic [CNT_W-1:0]        total_count,
    output logic [LAT_W-1:0]        min_latency,
    output logic [LAT_W-1:0]        max_latency,
    output logic [CNT_W-1:0]        anomaly_total,
    output logic [CNT_W-1:0]        long_total,
    output logic [CNT_W-1:0]        short_total,
    output logic [CNT_W-1:0]        read_a,
    output logic [TIMING_W-1:0]     read_b,
    output logic [FILL_W-1:0]       log_fill
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DIV,
        S_EVAL,
        S_UPD
    } state_t;

    state_t state_reg;

    // item held for the whole command
    logic [1:0]        cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [LAT_W-1:0]  lat_reg;
    logic [LAT_W-1:0]  exp_reg;
    logic              neg_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              in_range_reg;
    logic signed [DEV_W-1:0] dev_reg;
    logic              anom_reg;

    // threshold and statistics; the statistics change only when a result is
    // loaded, so the ports read them directly and they hold while a result is stalled
    logic [THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [LAT_W-1:0]  min_reg;
    logic [LAT_W-1:0]  max_reg;
    logic [CNT_W-1:0]  anom_cnt_reg;
    logic [CNT_W-1:0]  long_cnt_reg;
    logic [CNT_W-1:0]  short_cnt_reg;

    // result registers
    logic                    out_valid_reg;
    logic signed [DEV_W-1:0] dev_out_reg;
    bit_type_t               type_reg;
    logic                    logged_reg;
    logic [CNT_W-1:0]        read_a_reg;
    logic [TIMING_W-1:0]     read_b_reg;

    // submodule hookup
    hist_ctl_t         hist_ctl;
    logic [CNT_W-1:0]  hist_rdata;
    logic              hist_clr_busy;
    log_ctl_t          log_ctl;
    log_entry_t        log_wr;
    log_entry_t        log_rd;
    logic              log_hit;
    logic [LOG_CW-1:0] log_count;
    logic              log_full;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_quot;

    // accept-cycle arithmetic on the input ports
    logic              in_acc;
    logic [LAT_W:0]    diff;
    logic [LAT_W-1:0]  diff_mag;

    // evaluation of the quotient
    logic signed [DEV_W-1:0] dev_next;
    logic [DEV_W-1:0]        mag_next;

    // result assembly
    logic              out_free;
    logic              upd_fire;
    logic              is_record;
    logic              anom_log;
    bit_type_t         type_next;
    logic [CNT_W-1:0]  read_a_next;
    logic [TIMING_W-1:0] read_b_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_record = (cmd_reg == CMD_RECORD);
    assign upd_fire  = (state_reg == S_UPD) && out_free;
    assign anom_log  = is_record && anom_reg && !log_full;

    always_comb
    begin
        diff     = {1'b0, interval_ns} - {1'b0, nominal_ns};
        diff_mag = diff[LAT_W] ? LAT_W'(-diff) : diff[LAT_W-1:0];
    end

    // memory and divider control: reads and divider start in the lookup cycle, writes on update
    always_comb
    begin
        hist_ctl.rd_en  = (state_reg == S_LOOK) && in_range_reg &&
                          (is_record || (cmd_reg == CMD_HIST_RD));
        hist_ctl.inc_en = upd_fire && is_record && in_range_reg;
        log_ctl.rd_en     = (state_reg == S_LOOK) && (cmd_reg == CMD_LOG_RD);
        log_ctl.append_en = upd_fire && anom_log;
        div_start = (state_reg == S_LOOK) && is_record && (exp_reg != '0);
        log_wr.pos    = pos_reg;
        log_wr.timing = {lat_reg, exp_reg, dev_reg};
    end

    // quotient to clamped percent and its magnitude
    always_comb
    begin
        if (!is_record || (exp_reg == '0))
        begin
            dev_next = '0;
            mag_next = '0;
        end
        else if (neg_reg)
        begin
            if (div_quot >= DVD_W'(DEV_MIN_MAG))
            begin
                dev_next = DEV_W'(-DEV_MIN_MAG);
                mag_next = DEV_W'(DEV_MIN_MAG);
            end
            else
            begin
                dev_next = -$signed(div_quot[DEV_W-1:0]);
                mag_next = div_quot[DEV_W-1:0];
            end
        end
        else
        begin
            if (div_quot >= DVD_W'(DEV_MAX))
            begin
                dev_next = DEV_W'(DEV_MAX);
                mag_next = DEV_W'(DEV_MAX);
            end
            else
            begin
                dev_next = $signed(div_quot[DEV_W-1:0]);
                mag_next = div_quot[DEV_W-1:0];
            end
        end
    end

    // result fields
    always_comb
    begin
        if (is_record && anom_reg)
        begin
            type_next = dev_reg[DEV_W-1] ? BT_SHORT : BT_LONG;
        end
        else
        begin
            type_next = BT_NORMAL;
        end
        unique case (cmd_reg)
            CMD_HIST_RD:
            begin
                read_a_next = in_range_reg ? hist_rdata : '0;
                read_b_next = '0;
            end
            CMD_LOG_RD:
            begin
                read_a_next = log_hit ? log_rd.pos : '0;
                read_b_next = log_hit ? log_rd.timing : '0;
            end
            default:
            begin
                read_a_next = '0;
                read_b_next = '0;
            end
        endcase
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            dev_out_reg   <= '0;
            type_reg      <= BT_NORMAL;
            logged_reg    <= 1'b0;
            read_a_reg    <= '0;
            read_b_reg    <= '0;
        end
        else
        begin
            // a new result loads over a taken or empty slot
            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (!hist_clr_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= div_start ? S_DIV : S_EVAL;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (out_free)
                    begin
                        state_reg   <= S_IDLE;
                        dev_out_reg <= dev_reg;
                        type_reg    <= type_next;
                        logged_reg  <= anom_log;
                        read_a_reg  <= read_a_next;
                        read_b_reg  <= read_b_next;
                    end
                end
            endcase
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg      <= cmd;
            pos_reg      <= bit_pos;
            lat_reg      <= interval_ns;
            exp_reg      <= nominal_ns;
            neg_reg      <= diff[LAT_W];
            dvd_reg      <= DVD_W'(diff_mag) * DVD_W'(PCT_SCALE);
            prod_reg     <= PROD_W'(interval_ns) * PROD_W'(RECIP);
            in_range_reg <= (32'(interval_ns) < 32'(HIST_SPAN_NS));
        end
        if (state_reg == S_EVAL)
        begin
            dev_reg  <= dev_next;
            anom_reg <= (mag_next > thr_reg);
        end
    end

    // threshold register and running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_W'(THR_RESET);
            total_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            anom_cnt_reg  <= '0;
            long_cnt_reg  <= '0;
            short_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (upd_fire && is_record)
            begin
                total_reg <= total_reg + CNT_W'(1);
                if (lat_reg < min_reg)
                begin
                    min_reg <= lat_reg;
                end
                if (lat_reg > max_reg)
                begin
                    max_reg <= lat_reg;
                end
                if (anom_reg)
                begin
                    anom_cnt_reg <= anom_cnt_reg + CNT_W'(1);
                    if (dev_reg[DEV_W-1])
                    begin
                        short_cnt_reg <= short_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        long_cnt_reg <= long_cnt_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    // deviation divider: |(lat - exp) * 100| / exp
    fitm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (exp_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // bucket index is the high part of latency times the bucket reciprocal
    fitm_hist u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hist_ctl),
        .rd_addr  (prod_reg[RECIP_SH +: HIST_AW]),
        .rd_data  (hist_rdata),
        .clr_busy (hist_clr_busy)
    );

    fitm_log u_log (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (log_ctl),
        .rd_idx   (pos_reg),
        .wr_entry (log_wr),
        .rd_entry (log_rd),
        .rd_hit   (log_hit),
        .count    (log_count),
        .full     (log_full)
    );

    assign out_valid     = out_valid_reg;
    assign dev_pct       = dev_out_reg;
    assign bit_type      = type_reg;
    assign logged        = logged_reg;
    assign read_a        = read_a_reg;
    assign read_b        = read_b_reg;
    assign total_count   = total_reg;
    assign min_latency   = min_reg;
    assign max_latency   = max_reg;
    assign anomaly_total = anom_cnt_reg;
    assign long_total    = long_cnt_reg;
    assign short_total   = short_cnt_reg;
    assign log_fill      = FILL_W'(log_count);

    `ASSERT_NEVER(a_logged_normal, logged_reg && (type_reg == BT_NORMAL), "logged normal beat")
    `ASSERT_NEVER(a_accept_in_clear, hist_clr_busy && (state_reg != S_CLEAR), "left clear early")

endmodule
